// File: design/ddamr_pkg.sv
// shared types and constants for the differential drive mixer with ramp
package ddamr_pkg;

    localparam int LVL_W     = 11;
    localparam int US_W      = 11;
    localparam int DUTY_W    = 13;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 104;
    localparam int OP_W      = 2;

    // quotient bits of the mixer divider and its step counter width
    localparam int DIV_STEPS = 10;
    localparam int DIV_CNT_W = 4;

    localparam logic [OP_W-1:0] OP_CMD  = 2'd0;
    localparam logic [OP_W-1:0] OP_TMO  = 2'd1;
    localparam logic [OP_W-1:0] OP_RAMP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd5;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load_in;
        logic do_tmo;
        logic do_op;
        logic do_mul;
        logic div_step;
        logic do_tgt;
        logic do_pulse;
        logic do_out;
    } t_dp_cmd;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic is_cmd;
        logic need_mix;
        logic out_free;
    } t_dp_sts;

endpackage

// File: design/diff_drive_arm_mix_ramp.sv
// top level of the differential drive mixer with arming gate and slew limit
// Takes one transaction per item: tuser carries the opcode (command event,
// timeout check, or timeout check then ramp tick) and tdata the timestamp,
// sticks and flags. Every input transaction yields one output transaction with
// both ramped levels, ESC pulse widths, 13-bit duty counts at 50 Hz, the armed
// flag and the command count. Timestamps wrap modulo 2^32. Items are handled
// one at a time: a timeout check or ramp tick passes the timeout, operation,
// pulse and output states, a command event also the multiply state, and a
// command that retargets the motors also the ten-step restoring divider that
// scales both mixed targets by limit / max(1000, peak); the output state waits
// while a previous result is unread. The result sits in an output register,
// so the next item is taken while it waits. Configuration writes are taken at
// any edge with i_cfg_we high and must only come while the block is idle.
module diff_drive_arm_mix_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_ms[31:0], throttle[42:32], steering[53:43], enable_request[54],
    // stop_request[55], pwm_ok[56], zero fill
    input  logic [63:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_level[10:0], right_level[21:11], left_pulse_us[32:22],
    // right_pulse_us[43:33], left_duty[56:44], right_duty[69:57],
    // armed[70], commands_seen[102:71], zero fill
    output logic [103:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import ddamr_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: walks each transaction through its steps
    ddamr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    // datapath: state, mixing divider, ramps and output register
    ddamr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: design/ddamr_ctrl.sv
// sequencer for one transaction: timeout, operation, mix divide, pulse, output
module ddamr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ddamr_pkg::t_dp_sts i_sts,
    output ddamr_pkg::t_dp_cmd o_cmd,
    output logic              o_in_ready
);
    import ddamr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_TMO, S_OP, S_MUL, S_DIV, S_TGT, S_PULSE, S_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = S_TMO;
            end
            S_TMO: begin
                o_cmd.do_tmo = 1'b1;
                n_state = S_OP;
            end
            S_OP: begin
                o_cmd.do_op = 1'b1;
                n_state = i_sts.is_cmd ? S_MUL : S_PULSE;
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_cnt = '0;
                n_state = i_sts.need_mix ? S_DIV : S_PULSE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_TGT;
            end
            S_TGT: begin
                o_cmd.do_tgt = 1'b1;
                n_state = S_PULSE;
            end
            S_PULSE: begin
                o_cmd.do_pulse = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.do_out = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: design/ddamr_dp.sv
// datapath: config registers, arming state, mixer divider, ramps, output register
module ddamr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ddamr_pkg::t_dp_cmd                  i_cmd,
    output ddamr_pkg::t_dp_sts                  o_sts,
    input  logic [ddamr_pkg::OP_W-1:0]          i_op,
    input  logic [ddamr_pkg::IN_DATA_W-1:0]     i_data,
    input  logic                                i_cfg_we,
    input  logic [ddamr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ddamr_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [ddamr_pkg::OUT_DATA_W-1:0]    o_out_data
);
    import ddamr_pkg::*;

    localparam logic signed [LVL_W-1:0] LVL_MAX = 11'sd1000;
    localparam logic [US_W-1:0]         US_MID  = 11'd1500;
    localparam logic [25:0]             DUTY_K  = 26'd54975582;
    localparam logic [36:0]             DUTY_HALF = 37'd8388608;

    function automatic logic signed [LVL_W-1:0] clamp_stick(input logic signed [LVL_W-1:0] v);
        if (v > LVL_MAX)       return LVL_MAX;
        else if (v < -LVL_MAX) return -LVL_MAX;
        else                   return v;
    endfunction

    function automatic logic signed [1:0] sgn(input logic signed [12:0] v);
        if (v > 13'sd0)      return 2'sd1;
        else if (v < 13'sd0) return -2'sd1;
        else                 return 2'sd0;
    endfunction

    // configuration
    logic [9:0]  r_cfg_limit, r_cfg_step;
    logic [15:0] r_cfg_startup, r_cfg_timeout, r_cfg_pause;
    logic [31:0] r_cfg_start;

    // latched transaction
    logic [OP_W-1:0]         r_op;
    logic [TIME_W-1:0]       r_now;
    logic signed [LVL_W-1:0] r_thr, r_str;
    logic                    r_en, r_stop, r_rdy;

    // block state
    logic r_armed, n_armed, r_rc, n_rc, r_seen, n_seen, r_need_mix, n_need_mix;
    logic [TIME_W-1:0]       r_last, n_last;
    logic [CNT_W-1:0]        r_ccnt, n_ccnt;
    logic signed [LVL_W-1:0] r_tgt [2], n_tgt [2];
    logic signed [LVL_W-1:0] r_lvl [2], n_lvl [2];
    logic signed [1:0]       r_dir [2], n_dir [2];
    logic [TIME_W-1:0]       r_ns  [2], n_ns  [2];

    // mixer operands and divider
    logic [10:0] r_al, r_ar, r_peak;
    logic        r_sl, r_sr;
    logic [10:0] r_rem [2];
    logic [9:0]  r_dvd [2];

    // pulse stage
    logic [US_W-1:0] r_us [2];
    logic [36:0]     r_dprod [2];

    // output register
    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic signed [LVL_W-1:0] c_tc, c_sc;
    logic signed [11:0]      c_l, c_r;
    logic [10:0]             c_al, c_ar, c_pk;
    logic [9:0]              c_lim;
    logic                    c_centered;

    assign c_tc = clamp_stick(r_thr);
    assign c_sc = clamp_stick(r_str);
    assign c_l  = 12'(c_tc) + 12'(c_sc);
    assign c_r  = 12'(c_tc) - 12'(c_sc);
    assign c_al = c_l[11] ? 11'(-c_l) : 11'(c_l);
    assign c_ar = c_r[11] ? 11'(-c_r) : 11'(c_r);
    assign c_pk = (c_al > c_ar) ? c_al : c_ar;
    assign c_lim = (r_cfg_limit > 10'd1000) ? 10'd1000 : r_cfg_limit;
    assign c_centered = (r_thr == '0) && (r_str == '0);

    always_comb begin
        logic               halt;
        logic signed [12:0] tgt, val, nv, stp;
        logic signed [1:0]  dir;
        n_armed = r_armed;
        n_rc    = r_rc;
        n_seen  = r_seen;
        n_last  = r_last;
        n_ccnt  = r_ccnt;
        n_need_mix = r_need_mix;
        n_tgt = r_tgt;
        n_lvl = r_lvl;
        n_dir = r_dir;
        n_ns  = r_ns;
        halt = 1'b0;
        tgt  = '0;
        val  = '0;
        nv   = '0;
        dir  = '0;
        stp = $signed({3'b000, r_cfg_step});

        if (i_cmd.do_tmo && (r_op == OP_CMD || r_op == OP_TMO || r_op == OP_RAMP)) begin
            halt = r_seen && ((r_now - r_last) > {16'h0, r_cfg_timeout});
        end
        if (i_cmd.do_op && r_op == OP_CMD) begin
            n_last = r_now;
            n_seen = 1'b1;
            n_ccnt = r_ccnt + 1'b1;
            n_need_mix = 1'b0;
            if (!r_rdy || r_stop || ((r_now - r_cfg_start) < {16'h0, r_cfg_startup})) begin
                halt = 1'b1;
            end else if (!r_en) begin
                halt = 1'b1;
            end else if (!r_armed) begin
                if (!r_rc || !c_centered) begin
                    n_rc = 1'b0;
                end else begin
                    n_armed = 1'b1;
                    n_rc = 1'b0;
                    n_need_mix = 1'b1;
                end
            end else begin
                n_need_mix = 1'b1;
            end
        end
        if (halt) begin
            n_armed = 1'b0;
            n_rc    = 1'b0;
            for (int i = 0; i < 2; i++) begin
                n_tgt[i] = '0;
                if (r_lvl[i] != '0) begin
                    n_ns[i]  = r_now;
                    n_lvl[i] = '0;
                end
            end
        end
        // enable released: remember whether both sticks were centered
        if (i_cmd.do_op && r_op == OP_CMD && r_rdy && !r_stop && !r_en &&
            !((r_now - r_cfg_start) < {16'h0, r_cfg_startup})) begin
            n_rc = c_centered;
        end

        if (i_cmd.do_op && r_op == OP_RAMP) begin
            for (int i = 0; i < 2; i++) begin
                tgt = 13'(r_tgt[i]);
                val = 13'(r_lvl[i]);
                dir = sgn(tgt);
                // hold neutral before a direction reversal
                if (dir != 2'sd0 && r_dir[i] != 2'sd0 && dir != r_dir[i] &&
                    (r_lvl[i] != '0 || ((r_now - r_ns[i]) < {16'h0, r_cfg_pause}))) begin
                    tgt = '0;
                end
                if (val < tgt) begin
                    nv = val + stp;
                    if (nv > tgt) nv = tgt;
                end else if (val > tgt) begin
                    nv = val - stp;
                    if (nv < tgt) nv = tgt;
                end else begin
                    nv = val;
                end
                n_lvl[i] = nv[LVL_W-1:0];
                if (nv != '0) n_dir[i] = sgn(nv);
                else if (r_lvl[i] != '0) n_ns[i] = r_now;
            end
        end

        if (i_cmd.do_tgt) begin
            n_tgt[0] = r_sl ? -$signed({1'b0, r_dvd[0]}) : $signed({1'b0, r_dvd[0]});
            n_tgt[1] = r_sr ? -$signed({1'b0, r_dvd[1]}) : $signed({1'b0, r_dvd[1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit   <= 10'd250;
            r_cfg_startup <= 16'd3000;
            r_cfg_timeout <= 16'd400;
            r_cfg_pause   <= 16'd300;
            r_cfg_step    <= 10'd10;
            r_cfg_start   <= '0;
            r_armed <= 1'b0;
            r_rc    <= 1'b0;
            r_seen  <= 1'b0;
            r_last  <= '0;
            r_ccnt  <= '0;
            r_need_mix <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_tgt[i] <= '0;
                r_lvl[i] <= '0;
                r_dir[i] <= '0;
                r_ns[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LIMIT:   r_cfg_limit   <= i_cfg_data[9:0];
                    CFG_STARTUP: r_cfg_startup <= i_cfg_data[15:0];
                    CFG_TIMEOUT: r_cfg_timeout <= i_cfg_data[15:0];
                    CFG_PAUSE:   r_cfg_pause   <= i_cfg_data[15:0];
                    CFG_STEP:    r_cfg_step    <= i_cfg_data[9:0];
                    CFG_START:   r_cfg_start   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_armed <= n_armed;
            r_rc    <= n_rc;
            r_seen  <= n_seen;
            r_last  <= n_last;
            r_ccnt  <= n_ccnt;
            r_need_mix <= n_need_mix;
            r_tgt <= n_tgt;
            r_lvl <= n_lvl;
            r_dir <= n_dir;
            r_ns  <= n_ns;
            if (i_cmd.do_out)   r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        logic [20:0] prod;
        logic [11:0] sh;
        logic [US_W-1:0] us;
        logic signed [LVL_W-1:0] half;
        if (i_cmd.load_in) begin
            r_op   <= i_op;
            r_now  <= i_data[31:0];
            r_thr  <= i_data[42:32];
            r_str  <= i_data[53:43];
            r_en   <= i_data[54];
            r_stop <= i_data[55];
            r_rdy  <= i_data[56];
        end
        if (i_cmd.do_op) begin
            r_al   <= c_al;
            r_ar   <= c_ar;
            r_sl   <= c_l[11];
            r_sr   <= c_r[11];
            r_peak <= (c_pk < 11'd1000) ? 11'd1000 : c_pk;
        end
        if (i_cmd.do_mul) begin
            prod = 21'(r_al * c_lim);
            r_rem[0] <= prod[20:10];
            r_dvd[0] <= prod[9:0];
            prod = 21'(r_ar * c_lim);
            r_rem[1] <= prod[20:10];
            r_dvd[1] <= prod[9:0];
        end
        if (i_cmd.div_step) begin
            for (int i = 0; i < 2; i++) begin
                sh = {r_rem[i], r_dvd[i][9]};
                if (sh >= {1'b0, r_peak}) begin
                    r_rem[i] <= 11'(sh - {1'b0, r_peak});
                    r_dvd[i] <= {r_dvd[i][8:0], 1'b1};
                end else begin
                    r_rem[i] <= sh[10:0];
                    r_dvd[i] <= {r_dvd[i][8:0], 1'b0};
                end
            end
        end
        if (i_cmd.do_pulse) begin
            for (int i = 0; i < 2; i++) begin
                // level / 2 truncated toward zero
                half = (r_lvl[i] + $signed(LVL_W'(r_lvl[i] < 0))) >>> 1;
                us = r_rdy ? US_W'($signed({1'b0, US_MID}) + 12'(half)) : '0;
                r_us[i]    <= us;
                r_dprod[i] <= 37'(us * DUTY_K) + DUTY_HALF;
            end
        end
        if (i_cmd.do_out) begin
            r_odata <= {1'b0, r_ccnt, r_armed, r_dprod[1][36:24], r_dprod[0][36:24],
                        r_us[1], r_us[0], r_lvl[1], r_lvl[0]};
        end
    end

    assign o_sts.is_cmd   = (r_op == OP_CMD);
    assign o_sts.need_mix = r_need_mix;
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

`ifndef SYNTH
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl[0] <= LVL_MAX && r_lvl[0] >= -LVL_MAX &&
        r_lvl[1] <= LVL_MAX && r_lvl[1] >= -LVL_MAX)
        else $error("motor level out of range");
    a_tgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tgt[0] <= LVL_MAX && r_tgt[0] >= -LVL_MAX &&
        r_tgt[1] <= LVL_MAX && r_tgt[1] >= -LVL_MAX)
        else $error("target out of range");
    a_tgt_only_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_tgt |=> r_armed)
        else $error("targets set while disarmed");
    a_rem_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem[0] < r_peak && r_rem[1] < r_peak))
        else $error("divider remainder not reduced");
`endif

endmodule

// File: bench/diff_drive_arm_mix_ramp_test.sv
// self-checking testbench for the differential drive mixer with arming gate and ramp
module diff_drive_arm_mix_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ddamr_pkg::*;

    // one input transaction
    typedef struct {
        logic [1:0]  op;
        logic [31:0] now;
        logic [10:0] thr;
        logic [10:0] str;
        logic        en;
        logic        stp;
        logic        rdy;
    } t_drive_item;

    // one output transaction, unpacked
    typedef struct packed {
        logic [10:0] lvl_l;
        logic [10:0] lvl_r;
        logic [10:0] us_l;
        logic [10:0] us_r;
        logic [12:0] duty_l;
        logic [12:0] duty_r;
        logic        arm;
        logic [31:0] cmds;
    } t_drive_status;

    // directed rows: item plus optional typed-in expectation
    typedef struct {
        t_drive_item   item;
        logic          fixed;
        t_drive_status want;
    } t_drive_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;

    diff_drive_arm_mix_ramp u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // mirror of the block's configuration
    logic [9:0]  lim_r;
    logic [15:0] delay_r, tmo_r, pause_r;
    logic [9:0]  step_r;
    logic [31:0] start_r;

    // mirror of the block's state
    logic        arm_m, rel_m, seen_m;
    logic [31:0] last_cmd_m, cmd_cnt_m;
    int          tgt_m[2], lvl_m[2], dir_m[2];
    logic [31:0] neut_m[2];

    t_drive_status expected_q[$];
    int  mismatch_cnt;
    int  send_idle_pct, recv_idle_pct;
    logic [31:0] clock_ms;   // running timestamp for random items

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // generous overall limit; the slowest run is well below a millisecond
    initial begin
        #20ms;
        $display("diff_drive_arm_mix_ramp regression: fail");
        $finish;
    end

    function automatic int sat_stick(int v);
        return v > 1000 ? 1000 : (v < -1000 ? -1000 : v);
    endfunction

    function automatic int sgn(int v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic void mirror_reset();
        lim_r = 10'd250; delay_r = 16'd3000; tmo_r = 16'd400;
        pause_r = 16'd300; step_r = 10'd10; start_r = '0;
        arm_m = 0; rel_m = 0; seen_m = 0; last_cmd_m = '0; cmd_cnt_m = '0;
        for (int i = 0; i < 2; i++) begin
            tgt_m[i] = 0; lvl_m[i] = 0; dir_m[i] = 0; neut_m[i] = '0;
        end
    endfunction

    // stop both sides and disarm
    function automatic void halt_sides(logic [31:0] now);
        arm_m = 0;
        rel_m = 0;
        for (int i = 0; i < 2; i++) begin
            tgt_m[i] = 0;
            if (lvl_m[i] != 0) begin
                neut_m[i] = now;
                lvl_m[i] = 0;
            end
        end
    endfunction

    function automatic void check_silence(logic [31:0] now);
        logic [31:0] gap;
        gap = now - last_cmd_m;
        if (seen_m && gap > {16'd0, tmo_r})
            halt_sides(now);
    endfunction

    // slew one side toward its target, holding neutral before a reversal
    function automatic void slew_side(int i, logic [31:0] now);
        int goal, v, was, d;
        logic [31:0] held;
        goal = tgt_m[i];
        v = lvl_m[i];
        was = v;
        d = sgn(goal);
        held = now - neut_m[i];
        if (d != 0 && dir_m[i] != 0 && d != dir_m[i] &&
            (v != 0 || held < {16'd0, pause_r}))
            goal = 0;
        if (v < goal) begin
            v += int'(step_r);
            if (v > goal) v = goal;
        end
        if (v > goal) begin
            v -= int'(step_r);
            if (v < goal) v = goal;
        end
        lvl_m[i] = v;
        if (v != 0)
            dir_m[i] = sgn(v);
        else if (was != 0)
            neut_m[i] = now;
    endfunction

    function automatic void mix_targets(int thr, int str);
        int l, r, pk, lm;
        l = sat_stick(thr) + sat_stick(str);
        r = sat_stick(thr) - sat_stick(str);
        pk = (l < 0 ? -l : l) > (r < 0 ? -r : r) ? (l < 0 ? -l : l) : (r < 0 ? -r : r);
        lm = lim_r > 10'd1000 ? 1000 : int'(lim_r);
        if (pk < 1000) pk = 1000;
        tgt_m[0] = l * lm / pk;
        tgt_m[1] = r * lm / pk;
    endfunction

    function automatic void handle_command(t_drive_item it);
        int thr, str;
        logic [31:0] since;
        bit centered;
        thr = int'($signed(it.thr));
        str = int'($signed(it.str));
        centered = (thr == 0 && str == 0);
        check_silence(it.now);
        last_cmd_m = it.now;
        seen_m = 1;
        cmd_cnt_m++;
        since = it.now - start_r;
        if (!it.rdy || it.stp || since < {16'd0, delay_r}) begin
            halt_sides(it.now);
            return;
        end
        if (!it.en) begin
            halt_sides(it.now);
            rel_m = centered;
            return;
        end
        if (!arm_m) begin
            if (!rel_m || !centered) begin
                rel_m = 0;
                return;
            end
            arm_m = 1;
            rel_m = 0;
        end
        mix_targets(thr, str);
    endfunction

    function automatic logic [10:0] pulse_width(int lvl, logic rdy);
        if (!rdy) return '0;
        return 11'(1500 + lvl * 500 / 1000);
    endfunction

    function automatic logic [12:0] duty_count(logic [10:0] us);
        longint unsigned x;
        x = (longint'(us) * 50 * 65536 + 500000) / 1000000;
        return 13'(x);
    endfunction

    // advance the mirror by one item and return the status it should report
    function automatic t_drive_status predict_status(t_drive_item it);
        t_drive_status s;
        case (it.op)
            OP_CMD:  handle_command(it);
            OP_TMO:  check_silence(it.now);
            OP_RAMP: begin
                check_silence(it.now);
                slew_side(0, it.now);
                slew_side(1, it.now);
            end
            default: ;  // unused opcode only reports
        endcase
        s.lvl_l  = 11'(lvl_m[0]);
        s.lvl_r  = 11'(lvl_m[1]);
        s.us_l   = pulse_width(lvl_m[0], it.rdy);
        s.us_r   = pulse_width(lvl_m[1], it.rdy);
        s.duty_l = duty_count(s.us_l);
        s.duty_r = duty_count(s.us_r);
        s.arm    = arm_m;
        s.cmds   = cmd_cnt_m;
        return s;
    endfunction

    function automatic void mirror_config(logic [2:0] idx, logic [31:0] val);
        case (idx)
            CFG_LIMIT:   lim_r   = val[9:0];
            CFG_STARTUP: delay_r = val[15:0];
            CFG_TIMEOUT: tmo_r   = val[15:0];
            CFG_PAUSE:   pause_r = val[15:0];
            CFG_STEP:    step_r  = val[9:0];
            CFG_START:   start_r = val;
            default: ;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror_config(idx, val);
        @(posedge i_clk);
    endtask

    // wait for all results, then keep waiting so the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // push one transaction through the slave side, with random sender gaps
    task automatic send_item(t_drive_item it, logic fixed, t_drive_status want);
        t_drive_status exp_s;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {7'd0, it.rdy, it.stp, it.en, it.str, it.thr, it.now};
        do @(posedge i_clk); while (!s_axis_tready);
        exp_s = predict_status(it);
        expected_q.push_back(fixed ? want : exp_s);
    endtask

    function automatic t_drive_item make_item(logic [1:0] op, logic [31:0] now, int thr,
                                              int str, bit en, bit stp, bit rdy);
        t_drive_item it;
        it.op = op; it.now = now; it.thr = 11'(thr); it.str = 11'(str);
        it.en = en; it.stp = stp; it.rdy = rdy;
        return it;
    endfunction

    // random item: mostly a well-formed arming and driving sequence
    task automatic random_burst();
        t_drive_status none;
        int kind;
        none = '{default: '0};
        kind = $urandom_range(99);
        clock_ms += $urandom_range(40);
        if (kind < 15) begin
            // release centered, then re-enable centered
            send_item(make_item(OP_CMD, clock_ms, 0, 0, 0, 0, 1), 0, none);
            clock_ms += $urandom_range(20);
            send_item(make_item(OP_CMD, clock_ms, 0, 0, 1, 0, 1), 0, none);
        end else if (kind < 45) begin
            send_item(make_item(OP_CMD, clock_ms, $urandom_range(2400) - 1200,
                                $urandom_range(2400) - 1200, $urandom_range(9) != 0,
                                $urandom_range(19) == 0, $urandom_range(14) != 0), 0, none);
        end else if (kind < 90) begin
            send_item(make_item(OP_RAMP, clock_ms, $urandom, $urandom, 1'($urandom),
                                1'($urandom), $urandom_range(9) != 0), 0, none);
        end else if (kind < 95) begin
            send_item(make_item(OP_TMO, clock_ms + $urandom_range(800), $urandom, $urandom,
                                1'($urandom), 1'($urandom), 1'($urandom)), 0, none);
        end else begin
            // raw noise on every bit, timestamp included
            send_item(make_item(2'($urandom), $urandom, int'($urandom), int'($urandom),
                                1'($urandom), 1'($urandom), 1'($urandom)), 0, none);
            clock_ms = $urandom;
        end
    endtask

    // receiver: random stalls, compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_drive_status got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.lvl_l  = m_axis_tdata[10:0];
            got.lvl_r  = m_axis_tdata[21:11];
            got.us_l   = m_axis_tdata[32:22];
            got.us_r   = m_axis_tdata[43:33];
            got.duty_l = m_axis_tdata[56:44];
            got.duty_r = m_axis_tdata[69:57];
            got.arm    = m_axis_tdata[70];
            got.cmds   = m_axis_tdata[102:71];
            if (expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected output transaction %h", m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        m_axis_tready <= i_rst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
    end

    t_drive_row rows[$];
    t_drive_status idle_s;

    initial begin
        t_drive_row r;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        mismatch_cnt = 0;
        send_idle_pct = 38;
        recv_idle_pct = 61;
        mirror_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // status straight after reset, PWM ready: neutral pulse 1500 -> duty 4915
        idle_s = '{lvl_l: 0, lvl_r: 0, us_l: 1500, us_r: 1500, duty_l: 4915,
                   duty_r: 4915, arm: 0, cmds: 0};
        r.fixed = 1; r.want = idle_s;
        r.item = make_item(OP_TMO, 0, 0, 0, 0, 0, 1); rows.push_back(r);
        r.item = make_item(OP_RAMP, 0, 0, 0, 0, 0, 1); rows.push_back(r);
        // unused opcode, PWM off: everything reads zero
        r.want = '{default: '0};
        r.item = make_item(2'd3, 32'hFFFF_FFFF, -1024, 1023, 1, 1, 0); rows.push_back(r);
        r.fixed = 0;
        // inside startup delay: command counted but stays halted
        r.item = make_item(OP_CMD, 100, 1000, -1000, 1, 0, 1); rows.push_back(r);
        // arming sequence after the delay, then full stick extremes
        r.item = make_item(OP_CMD, 3000, 0, 0, 0, 0, 1); rows.push_back(r);
        r.item = make_item(OP_CMD, 3010, 0, 0, 1, 0, 1); rows.push_back(r);
        r.item = make_item(OP_CMD, 3020, 1023, -1024, 1, 0, 1); rows.push_back(r);
        r.item = make_item(OP_RAMP, 3030, 0, 0, 0, 0, 1); rows.push_back(r);
        r.item = make_item(OP_RAMP, 3040, 0, 0, 0, 0, 1); rows.push_back(r);
        r.item = make_item(OP_CMD, 3050, -1000, -1000, 1, 0, 1); rows.push_back(r);
        r.item = make_item(OP_RAMP, 3060, 0, 0, 0, 0, 1); rows.push_back(r);
        // reversal request while moving: must pass through neutral first
        r.item = make_item(OP_CMD, 3070, 1000, 1000, 1, 0, 1); rows.push_back(r);
        r.item = make_item(OP_RAMP, 3080, 0, 0, 0, 0, 0); rows.push_back(r);
        r.item = make_item(OP_RAMP, 3500, 0, 0, 0, 0, 1); rows.push_back(r);
        // stop while moving
        r.item = make_item(OP_CMD, 3510, 500, 0, 1, 1, 1); rows.push_back(r);
        // PWM not ready on a command
        r.item = make_item(OP_CMD, 3520, 0, 0, 1, 0, 0); rows.push_back(r);
        // command silence longer than the timeout
        r.item = make_item(OP_TMO, 4500, 0, 0, 0, 0, 1); rows.push_back(r);
        r.item = make_item(OP_RAMP, 32'hFFFF_FFFF, 0, 0, 0, 0, 1); rows.push_back(r);

        foreach (rows[k])
            send_item(rows[k].item, rows[k].fixed, rows[k].want);
        drain();

        // several register settings, extremes among them
        clock_ms = 32'd10000;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_LIMIT, 1000); write_reg(CFG_STEP, 1000);
                    write_reg(CFG_PAUSE, 0); write_reg(CFG_STARTUP, 0);
                    write_reg(CFG_TIMEOUT, 65535); write_reg(CFG_START, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(CFG_LIMIT, 1023); write_reg(CFG_STEP, 0);
                    write_reg(CFG_TIMEOUT, 1); write_reg(CFG_PAUSE, 65535);
                    write_reg(CFG_STARTUP, 65535); write_reg(CFG_START, clock_ms - 70000);
                end
                2: begin
                    write_reg(CFG_LIMIT, 0); write_reg(CFG_STEP, 1);
                    write_reg(CFG_TIMEOUT, 200); write_reg(CFG_PAUSE, 50);
                end
                3: begin
                    write_reg(CFG_LIMIT, $urandom_range(1023));
                    write_reg(CFG_STEP, $urandom_range(1, 300));
                    write_reg(CFG_TIMEOUT, $urandom_range(30, 500));
                    write_reg(CFG_PAUSE, $urandom_range(100));
                    write_reg(CFG_STARTUP, $urandom_range(20));
                    write_reg(CFG_START, clock_ms);
                    write_reg(3'd7, $urandom);  // index beyond the list is ignored
                    send_idle_pct = 61; recv_idle_pct = 38;
                end
                4: begin
                    write_reg(CFG_LIMIT, 600); write_reg(CFG_STEP, 37);
                    write_reg(CFG_TIMEOUT, 400); write_reg(CFG_PAUSE, 30);
                end
                default: begin
                    write_reg(CFG_LIMIT, 250); write_reg(CFG_STEP, 10);
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 90; n++)
                random_burst();
            drain();
        end

        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("diff_drive_arm_mix_ramp regression: pass");
        else
            $display("diff_drive_arm_mix_ramp regression: fail");
        $finish;
    end
endmodule
